[rtl/byte_memory_with_hex_image_loader_assert.svh]
// Assertion macros for the byte memory with hex image loader.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BYTE_MEMORY_WITH_HEX_IMAGE_LOADER_ASSERT_SVH
`define BYTE_MEMORY_WITH_HEX_IMAGE_LOADER_ASSERT_SVH

// same-cycle implication
`define BMHL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// delayed implication
`define BMHL_ASSERT_LAT3(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##3 (cons)) else $error(msg);

`endif

[rtl/bmhl_pkg.sv]
// Shared types and constants for the byte memory with hex image loader.
// No dependencies.
package bmhl_pkg;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_LOAD_CHAR = 2'd2,
        OP_LOAD_END  = 2'd3
    } t_op;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic CFG_BASE_ADDR  = 1'b0;
    localparam logic CFG_BIG_ENDIAN = 1'b1;

    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [3:0] MAX_DIGITS = 4'd9;

    // loader word store request and status toward the access stage
    typedef struct packed {
        logic        store;
        logic [31:0] addr;
        logic [31:0] data;
        logic        stopped;
    } t_ldr_out;

endpackage

[rtl/bmhl_lane_ram.sv]
// One byte lane of the memory: single port, registered read data.
// No dependencies.
module bmhl_lane_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bmhl_loader.sv]
// Hex image loader: token parser and load address state.
// Depends on bmhl_pkg.
module bmhl_loader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bmhl_pkg::t_op      i_op,
    input  logic [7:0]         i_char,
    output bmhl_pkg::t_ldr_out o_ldr
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOKEN,
        PH_STOPPED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_tok_addr, n_tok_addr;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_val, n_val;
    logic [31:0] r_load_addr, n_load_addr;

    logic        is_hex;
    logic        is_blank;
    logic [3:0]  hv;
    logic        do_finish;
    logic        store;

    always_comb begin
        is_hex = 1'b1;
        hv     = 4'd0;
        case (i_char) inside
            [8'h30:8'h39]: hv = 4'(i_char - 8'h30);
            [8'h61:8'h66]: hv = 4'(i_char - 8'h57);
            [8'h41:8'h46]: hv = 4'(i_char - 8'h37);
            default:       is_hex = 1'b0;
        endcase
        case (i_char) inside
            8'h20, [8'h09:8'h0D]: is_blank = 1'b1;
            default:              is_blank = 1'b0;
        endcase
    end

    assign do_finish = i_valid && (r_phase == PH_TOKEN) &&
                       ((i_op == bmhl_pkg::OP_LOAD_CHAR && !is_hex) ||
                        (i_op == bmhl_pkg::OP_LOAD_END));

    always_comb begin
        n_phase     = r_phase;
        n_tok_addr  = r_tok_addr;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_load_addr = r_load_addr;
        store       = 1'b0;

        if (i_valid && i_op == bmhl_pkg::OP_LOAD_CHAR) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_char == bmhl_pkg::CHAR_AT) begin
                        n_tok_addr = 1'b1;
                        n_cnt      = 4'd0;
                        n_val      = 32'd0;
                        n_phase    = PH_TOKEN;
                    end else if (is_hex) begin
                        n_tok_addr = 1'b0;
                        n_val      = {28'd0, hv};
                        n_cnt      = 4'd1;
                        n_phase    = PH_TOKEN;
                    end else if (!is_blank) begin
                        n_phase = PH_STOPPED;
                    end
                end
                PH_TOKEN: begin
                    if (is_hex && r_cnt < bmhl_pkg::MAX_DIGITS) begin
                        n_val = {r_val[27:0], hv};
                        n_cnt = r_cnt + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_finish) begin
            if (r_tok_addr) begin
                n_load_addr = r_val;
                n_tok_addr  = 1'b0;
            end else begin
                store       = 1'b1;
                n_load_addr = r_load_addr + 32'd4;
            end
            n_phase = PH_IDLE;
            n_cnt   = 4'd0;
            n_val   = 32'd0;
        end

        if (i_valid && i_op == bmhl_pkg::OP_LOAD_END) begin
            n_phase     = PH_IDLE;
            n_tok_addr  = 1'b0;
            n_cnt       = 4'd0;
            n_val       = 32'd0;
            n_load_addr = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tok_addr  <= 1'b0;
            r_cnt       <= 4'd0;
            r_val       <= 32'd0;
            r_load_addr <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_tok_addr  <= n_tok_addr;
            r_cnt       <= n_cnt;
            r_val       <= n_val;
            r_load_addr <= n_load_addr;
        end
    end

    assign o_ldr.store   = store;
    assign o_ldr.addr    = r_load_addr;
    assign o_ldr.data    = r_val;
    assign o_ldr.stopped = (n_phase == PH_STOPPED);

endmodule

[rtl/byte_memory_with_hex_image_loader.sv]
// Top level: byte memory with hex image loader, four byte-lane RAMs.
// Depends on bmhl_pkg, bmhl_loader, bmhl_lane_ram and the assert header.
//
//  channel   handshake                  payload
//  request   start / busy               i_operation, i_access_size, i_address,
//                                       i_write_data, i_text_char
//  result    o_strobe (one cycle)       o_read_data, o_in_range, o_word_loaded,
//                                       o_loader_stopped
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per cycle while busy is low; the result strobe follows the request
// through the input register, lane RAM access and result register.
// After reset, busy stays high while the lane RAMs are cleared one row per
// cycle; config writes are taken meanwhile.
// The result side cannot stall; busy is high only during the clearing pass.
`include "byte_memory_with_hex_image_loader_assert.svh"

module byte_memory_with_hex_image_loader #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_text_char,

    output logic        o_strobe,
    output logic [31:0] o_read_data,
    output logic        o_in_range,
    output logic        o_word_loaded,
    output logic        o_loader_stopped,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int LANE_DEPTH = (MEM_BYTES + 3) / 4;
    localparam int RW         = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
    localparam logic [RW-1:0] LAST_ROW = RW'(LANE_DEPTH - 1);

    // config
    logic [31:0] r_base;
    logic        r_be;

    // clearing pass
    logic          r_clearing;
    logic [RW-1:0] r_clr_row;

    // stage 1: input register
    logic          r_s1_valid;
    bmhl_pkg::t_op r_s1_op;
    logic [1:0]    r_s1_size;
    logic [31:0]   r_s1_addr;
    logic [31:0]   r_s1_wdata;
    logic [7:0]    r_s1_char;

    // stage 2: after lane RAM access
    logic       r_s2_valid;
    logic       r_s2_read;
    logic       r_s2_in_range;
    logic       r_s2_word_loaded;
    logic       r_s2_stopped;
    logic [1:0] r_s2_lo;
    logic [2:0] r_s2_n;
    logic       r_s2_be;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_in_range;
    logic        r_out_word_loaded;
    logic        r_out_stopped;

    bmhl_pkg::t_ldr_out ldr;

    logic          accept;
    logic          s1_mem_op;
    logic [31:0]   acc_addr;
    logic [31:0]   acc_data;
    logic [2:0]    acc_n;
    logic [31:0]   off;
    logic          fits;
    logic          do_write;
    logic [1:0]    lo;
    logic [RW-1:0] row0;
    logic [RW-1:0] row1;
    logic [31:0]   placed [4];
    logic [31:0]   assembled;

    assign accept      = start && !busy;
    assign busy        = r_clearing;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
            r_be   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bmhl_pkg::CFG_BASE_ADDR:  r_base <= i_cfg_data;
                bmhl_pkg::CFG_BIG_ENDIAN: r_be   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + RW'(1);
            if (r_clr_row == LAST_ROW) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_op    <= bmhl_pkg::t_op'(i_operation);
            r_s1_size  <= i_access_size;
            r_s1_addr  <= i_address;
            r_s1_wdata <= i_write_data;
            r_s1_char  <= i_text_char;
        end
    end

    bmhl_loader u_loader (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_op    (r_s1_op),
        .i_char  (r_s1_char),
        .o_ldr   (ldr)
    );

    assign s1_mem_op = (r_s1_op == bmhl_pkg::OP_READ) || (r_s1_op == bmhl_pkg::OP_WRITE);

    always_comb begin
        if (ldr.store) begin
            acc_n = 3'd4;
        end else begin
            case (r_s1_size)
                bmhl_pkg::SZ_BYTE: acc_n = 3'd1;
                bmhl_pkg::SZ_HALF: acc_n = 3'd2;
                bmhl_pkg::SZ_WORD: acc_n = 3'd4;
                default:           acc_n = 3'd0;
            endcase
        end
    end

    assign acc_addr = ldr.store ? ldr.addr : r_s1_addr;
    assign acc_data = ldr.store ? ldr.data : r_s1_wdata;
    assign off      = acc_addr - r_base;
    assign fits     = (acc_n != 3'd0) && (({1'b0, off} + 33'(acc_n)) <= MEM_LIMIT);
    assign do_write = r_s1_valid && fits &&
                      ((r_s1_op == bmhl_pkg::OP_WRITE) || ldr.store);
    assign lo       = off[1:0];
    assign row0     = off[RW+1:2];
    assign row1     = row0 + RW'(1);

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]    rel;
        logic          en;
        logic [2:0]    pos;
        logic [7:0]    wbyte;
        logic          we;
        logic [RW-1:0] addr;
        logic [7:0]    wdata;
        logic [7:0]    rdata;
        logic [1:0]    rel2;
        logic [2:0]    pos2;

        assign rel   = 2'(l) - lo;
        assign en    = {1'b0, rel} < acc_n;
        assign pos   = r_be ? (acc_n - 3'd1 - {1'b0, rel}) : {1'b0, rel};
        assign wbyte = acc_data[{pos[1:0], 3'b000} +: 8];

        assign we    = r_clearing || (do_write && en);
        assign addr  = r_clearing ? r_clr_row : ((2'(l) < lo) ? row1 : row0);
        assign wdata = r_clearing ? 8'd0 : wbyte;

        bmhl_lane_ram #(
            .DEPTH (LANE_DEPTH),
            .AW    (RW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_addr  (addr),
            .i_wdata (wdata),
            .o_rdata (rdata)
        );

        assign rel2 = 2'(l) - r_s2_lo;
        assign pos2 = r_s2_be ? (r_s2_n - 3'd1 - {1'b0, rel2}) : {1'b0, rel2};
        assign placed[l] = ({1'b0, rel2} < r_s2_n) ?
                           (32'(rdata) << {pos2[1:0], 3'b000}) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_read        <= (r_s1_op == bmhl_pkg::OP_READ) && fits;
        r_s2_in_range    <= fits && (s1_mem_op || ldr.store);
        r_s2_word_loaded <= ldr.store;
        r_s2_stopped     <= ldr.stopped;
        r_s2_lo          <= lo;
        r_s2_n           <= acc_n;
        r_s2_be          <= r_be;
    end

    assign assembled = placed[0] | placed[1] | placed[2] | placed[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2_valid;
        end
        r_out_data        <= r_s2_read ? assembled : 32'd0;
        r_out_in_range    <= r_s2_in_range;
        r_out_word_loaded <= r_s2_word_loaded;
        r_out_stopped     <= r_s2_stopped;
    end

    assign o_strobe         = r_out_valid;
    assign o_read_data      = r_out_data;
    assign o_in_range       = r_out_in_range;
    assign o_word_loaded    = r_out_word_loaded;
    assign o_loader_stopped = r_out_stopped;

    `BMHL_ASSERT_NOW(a_no_result_while_clearing, o_strobe, !r_clearing, "result during clear")
    `BMHL_ASSERT_NOW(a_out_of_range_zero, o_strobe && !o_in_range, o_read_data == 32'd0, "nonzero data")
    `BMHL_ASSERT_LAT3(a_request_latency, accept, o_strobe, "missing result strobe")

endmodule
